[rtl/core/vkt_pkg.sv]
// Shared types, widths and codes of the vehicle kinematic tracker.
package vkt_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned LANE_WIDTH_W = 21;
  localparam int unsigned HORIZON_W    = 20;
  localparam int unsigned LANE_W       = 8;
  localparam int unsigned SPEED_W      = 31;

  // Reset lane width is four meters in Q16.16.
  localparam logic [LANE_WIDTH_W-1:0] LANE_WIDTH_RESET = 21'd262144;

  // Shared square root and divide both retire one result bit per step.
  localparam int unsigned ITER_COUNT = 32;
  localparam int unsigned ITER_CNT_W = $clog2(ITER_COUNT);

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_PREDICT = 2'd2,
    OP_HOLD    = 2'd3
  } vkt_op_e;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_INIT,
    DP_DIFF_VEL,
    DP_DIFF_ACC,
    DP_SQ_X,
    DP_SQ_Y,
    DP_SQ_SUM,
    DP_ITER,
    DP_LANE,
    DP_MUL_A,
    DP_SPLIT,
    DP_MUL_PH,
    DP_MUL_PL,
    DP_HAT_Y,
    DP_HAT_POS,
    DP_MUL_V,
    DP_ADD_V,
    DP_MUL_SPD,
    DP_ADD_SPD,
    DP_OUT
  } vkt_dp_op_e;

  typedef struct packed {
    vkt_op_e                     op;
    logic signed [DATA_W-1:0]    pos_s;
    logic signed [DATA_W-1:0]    pos_d;
    logic signed [DATA_W-1:0]    vel_x;
    logic signed [DATA_W-1:0]    vel_y;
    logic        [HORIZON_W-1:0] horizon;
  } vkt_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  pred_s;
    logic signed [DATA_W-1:0]  pred_s_vel;
    logic signed [DATA_W-1:0]  s_accel;
    logic signed [DATA_W-1:0]  pred_d;
    logic signed [DATA_W-1:0]  pred_d_vel;
    logic signed [DATA_W-1:0]  d_accel;
    logic signed [DATA_W-1:0]  pred_s_by_speed;
    logic signed [LANE_W-1:0]  lane;
    logic        [SPEED_W-1:0] speed;
  } vkt_out_t;

  // Axis selects s (0) or d (1) for the per-axis prediction steps.
  typedef struct packed {
    vkt_dp_op_e op;
    logic       axis;
  } vkt_cmd_t;

  typedef struct packed {
    vkt_op_e op;
  } vkt_status_t;

endpackage

[rtl/core/vkt_dp.sv]
// Datapath of the vehicle kinematic tracker: track state, multipliers, root and divide.
module vkt_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vkt_pkg::vkt_cmd_t                      cmd_i,
  output vkt_pkg::vkt_status_t                   status_o,
  input  vkt_pkg::vkt_in_t                       in_data_i,
  input  logic                                   cfg_we_i,
  input  logic [vkt_pkg::LANE_WIDTH_W-1:0]       cfg_data_i,
  output vkt_pkg::vkt_out_t                      out_data_o
);

  localparam logic signed [vkt_pkg::LANE_W-1:0] LANE_MAX = 8'h7F;
  localparam logic signed [vkt_pkg::LANE_W-1:0] LANE_MIN = 8'h80;

  function automatic logic signed [47:0] ext32(input logic signed [31:0] v);
    ext32 = {{16{v[31]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (&v[47:31] || ~|v[47:31]) begin
      r = v[31:0];
    end else if (v[47]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    sat32 = r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // Configuration and track state.
  logic [vkt_pkg::LANE_WIDTH_W-1:0] lane_width_q;
  logic signed [31:0] s_pos_q, s_vel_q, s_acc_q;
  logic signed [31:0] d_pos_q, d_vel_q, d_acc_q;
  logic [vkt_pkg::SPEED_W-1:0] speed_q;
  logic signed [vkt_pkg::LANE_W-1:0] lane_q;

  // Working registers.
  vkt_pkg::vkt_op_e op_q;
  logic signed [31:0] in_s_q, in_d_q;
  logic [31:0] ax_q, ay_q;
  logic [vkt_pkg::HORIZON_W-1:0] t_q;
  logic signed [31:0] nv_s_q, nv_d_q;
  logic [63:0] sq_q, rad_q;
  logic [33:0] srem_q;
  logic [31:0] root_q;
  logic [vkt_pkg::LANE_WIDTH_W-1:0] drem_q;
  logic [31:0] dq_q;
  logic signed [57:0] prod_q;
  logic signed [35:0] ph_q;
  logic [15:0] pl_q;
  logic signed [57:0] y_q;
  logic signed [41:0] sum_q;
  logic signed [31:0] res_s_pos_q, res_s_vel_q, res_d_pos_q, res_d_vel_q, res_spd_q;
  vkt_pkg::vkt_out_t out_q;

  // Per-axis operand selection.
  logic signed [31:0] pos_x, vel_x, acc_x;
  assign pos_x = cmd_i.axis ? d_pos_q : s_pos_q;
  assign vel_x = cmd_i.axis ? d_vel_q : s_vel_q;
  assign acc_x = cmd_i.axis ? d_acc_q : s_acc_q;

  // Shared horizon multiplier: one signed operand times the horizon.
  logic signed [36:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [57:0] mul_p;

  always_comb begin
    case (cmd_i.op)
      vkt_pkg::DP_MUL_A:   mul_a = {{5{acc_x[31]}}, acc_x};
      vkt_pkg::DP_MUL_PH:  mul_a = {ph_q[35], ph_q};
      vkt_pkg::DP_MUL_PL:  mul_a = {21'd0, pl_q};
      vkt_pkg::DP_MUL_V:   mul_a = {{5{vel_x[31]}}, vel_x};
      vkt_pkg::DP_MUL_SPD: mul_a = {6'd0, speed_q};
      default:             mul_a = '0;
    endcase
  end

  assign mul_b = {1'b0, t_q};
  assign mul_p = 58'(mul_a) * 58'(mul_b);

  // Square unit for the velocity magnitude.
  logic [31:0] sq_in;
  logic [63:0] sq_p;
  assign sq_in = (cmd_i.op == vkt_pkg::DP_SQ_X) ? ax_q : ay_q;
  assign sq_p  = 64'(sq_in) * 64'(sq_in);

  // One step of the restoring square root.
  logic [35:0] srem_sh, s_trial, s_diff;
  logic        s_ge;
  assign srem_sh = {srem_q, rad_q[63:62]};
  assign s_trial = {2'b00, root_q, 2'b01};
  assign s_ge    = (srem_sh >= s_trial);
  assign s_diff  = srem_sh - s_trial;

  // One step of the restoring divide of |d| by the lane width.
  logic [vkt_pkg::LANE_WIDTH_W:0] drem_sh, d_div, d_diff;
  logic                           d_ge;
  assign drem_sh = {drem_q, dq_q[31]};
  assign d_div   = {1'b0, lane_width_q};
  assign d_ge    = (drem_sh >= d_div);
  assign d_diff  = drem_sh - d_div;

  // Lane from the quotient magnitude; the sign follows d.
  logic signed [vkt_pkg::LANE_W-1:0] lane_next;
  always_comb begin
    if (lane_width_q == '0) begin
      lane_next = in_d_q[31] ? LANE_MIN : LANE_MAX;
    end else if (!in_d_q[31]) begin
      lane_next = (dq_q >= 32'd126) ? LANE_MAX : (dq_q[7:0] + 8'd1);
    end else begin
      lane_next = (dq_q >= 32'd127) ? LANE_MIN : ~dq_q[7:0];
    end
  end

  logic [vkt_pkg::SPEED_W-1:0] speed_next;
  assign speed_next = root_q[31] ? '1 : root_q[30:0];

  // Differences for the update.
  logic signed [31:0] nv_s, nv_d, acc_s, acc_d;
  assign nv_s  = sat32(ext32(in_s_q) - ext32(s_pos_q));
  assign nv_d  = sat32(ext32(in_d_q) - ext32(d_pos_q));
  assign acc_s = sat32(ext32(nv_s_q) - ext32(s_vel_q));
  assign acc_d = sat32(ext32(nv_d_q) - ext32(d_vel_q));

  // Prediction sums. The velocity sum takes the floored a*t straight from the
  // product register, since ph_q is only loaded at the same edge.
  logic signed [47:0] vel_sum;
  logic signed [31:0] vel_pred;
  logic signed [57:0] y_add;
  logic signed [41:0] hat_sum, prod_sh, pos_sum, spd_sum;
  logic signed [31:0] pos_pred, spd_pred;

  assign vel_sum  = ext32(vel_x) + {{12{prod_q[51]}}, prod_q[51:16]};
  assign vel_pred = sat32(vel_sum);
  assign prod_sh  = prod_q[57:16];
  assign y_add    = y_q + {{16{prod_sh[41]}}, prod_sh};
  assign hat_sum  = {{10{pos_x[31]}}, pos_x} + {y_q[57], y_q[57:17]};
  assign pos_sum  = sum_q + prod_sh;
  assign pos_pred = sat32({{6{pos_sum[41]}}, pos_sum});
  assign spd_sum  = {{10{s_pos_q[31]}}, s_pos_q} + prod_sh;
  assign spd_pred = sat32({{6{spd_sum[41]}}, spd_sum});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_width_q <= vkt_pkg::LANE_WIDTH_RESET;
      s_pos_q      <= '0;
      s_vel_q      <= '0;
      s_acc_q      <= '0;
      d_pos_q      <= '0;
      d_vel_q      <= '0;
      d_acc_q      <= '0;
      speed_q      <= '0;
      lane_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        lane_width_q <= cfg_data_i;
      end
      case (cmd_i.op)
        vkt_pkg::DP_INIT: begin
          s_pos_q <= in_s_q;
          d_pos_q <= in_d_q;
          s_vel_q <= '0;
          s_acc_q <= '0;
          d_vel_q <= '0;
          d_acc_q <= '0;
        end
        vkt_pkg::DP_DIFF_ACC: begin
          s_acc_q <= acc_s;
          d_acc_q <= acc_d;
          s_vel_q <= nv_s_q;
          d_vel_q <= nv_d_q;
          s_pos_q <= in_s_q;
          d_pos_q <= in_d_q;
        end
        vkt_pkg::DP_LANE: begin
          speed_q <= speed_next;
          lane_q  <= lane_next;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      vkt_pkg::DP_LOAD: begin
        op_q   <= in_data_i.op;
        in_s_q <= in_data_i.pos_s;
        in_d_q <= in_data_i.pos_d;
        ax_q   <= abs32(in_data_i.vel_x);
        ay_q   <= abs32(in_data_i.vel_y);
        dq_q   <= abs32(in_data_i.pos_d);
        drem_q <= '0;
        t_q    <= (in_data_i.op == vkt_pkg::OP_PREDICT) ? in_data_i.horizon : '0;
      end
      vkt_pkg::DP_DIFF_VEL: begin
        nv_s_q <= nv_s;
        nv_d_q <= nv_d;
      end
      vkt_pkg::DP_SQ_X: begin
        sq_q <= sq_p;
      end
      vkt_pkg::DP_SQ_Y: begin
        rad_q <= sq_q;
        sq_q  <= sq_p;
      end
      vkt_pkg::DP_SQ_SUM: begin
        rad_q  <= rad_q + sq_q;
        srem_q <= '0;
        root_q <= '0;
      end
      vkt_pkg::DP_ITER: begin
        rad_q  <= {rad_q[61:0], 2'b00};
        srem_q <= s_ge ? s_diff[33:0] : srem_sh[33:0];
        root_q <= {root_q[30:0], s_ge};
        drem_q <= d_ge ? d_diff[vkt_pkg::LANE_WIDTH_W-1:0]
                       : drem_sh[vkt_pkg::LANE_WIDTH_W-1:0];
        dq_q   <= {dq_q[30:0], d_ge};
      end
      vkt_pkg::DP_MUL_A, vkt_pkg::DP_MUL_PH, vkt_pkg::DP_MUL_V,
      vkt_pkg::DP_MUL_SPD: begin
        prod_q <= mul_p;
      end
      vkt_pkg::DP_SPLIT: begin
        ph_q <= prod_q[51:16];
        pl_q <= prod_q[15:0];
        if (cmd_i.axis) begin
          res_d_vel_q <= vel_pred;
        end else begin
          res_s_vel_q <= vel_pred;
        end
      end
      vkt_pkg::DP_MUL_PL: begin
        y_q    <= prod_q;
        prod_q <= mul_p;
      end
      vkt_pkg::DP_HAT_Y: begin
        y_q <= y_add;
      end
      vkt_pkg::DP_HAT_POS: begin
        sum_q <= hat_sum;
      end
      vkt_pkg::DP_ADD_V: begin
        if (cmd_i.axis) begin
          res_d_pos_q <= pos_pred;
        end else begin
          res_s_pos_q <= pos_pred;
        end
      end
      vkt_pkg::DP_ADD_SPD: begin
        res_spd_q <= spd_pred;
      end
      vkt_pkg::DP_OUT: begin
        out_q.pred_s          <= res_s_pos_q;
        out_q.pred_s_vel      <= res_s_vel_q;
        out_q.s_accel         <= s_acc_q;
        out_q.pred_d          <= res_d_pos_q;
        out_q.pred_d_vel      <= res_d_vel_q;
        out_q.d_accel         <= d_acc_q;
        out_q.pred_s_by_speed <= res_spd_q;
        out_q.lane            <= lane_q;
        out_q.speed           <= speed_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.op = op_q;
  assign out_data_o  = out_q;

endmodule

[rtl/core/vkt_ctrl.sv]
// Sequencer of the vehicle kinematic tracker: handshakes, step order and iteration count.
module vkt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 cfg_ready_o,
  input  vkt_pkg::vkt_status_t status_i,
  output vkt_pkg::vkt_cmd_t    cmd_o
);

  typedef enum logic [20:0] {
    ST_IDLE     = 21'h000001,
    ST_DECODE   = 21'h000002,
    ST_INIT     = 21'h000004,
    ST_DIFF_VEL = 21'h000008,
    ST_DIFF_ACC = 21'h000010,
    ST_SQ_X     = 21'h000020,
    ST_SQ_Y     = 21'h000040,
    ST_SQ_SUM   = 21'h000080,
    ST_ITER     = 21'h000100,
    ST_LANE     = 21'h000200,
    ST_MUL_A    = 21'h000400,
    ST_SPLIT    = 21'h000800,
    ST_MUL_PH   = 21'h001000,
    ST_MUL_PL   = 21'h002000,
    ST_HAT_Y    = 21'h004000,
    ST_HAT_POS  = 21'h008000,
    ST_MUL_V    = 21'h010000,
    ST_ADD_V    = 21'h020000,
    ST_MUL_SPD  = 21'h040000,
    ST_ADD_SPD  = 21'h080000,
    ST_DONE     = 21'h100000
  } vkt_state_e;

  vkt_state_e state_q, state_d;
  logic [vkt_pkg::ITER_CNT_W-1:0] cnt_q, cnt_d;
  logic axis_q, axis_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = vkt_pkg::DP_NOP;
    cmd_o.axis  = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = vkt_pkg::DP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        axis_d = 1'b0;
        case (status_i.op)
          vkt_pkg::OP_INIT:   state_d = ST_INIT;
          vkt_pkg::OP_UPDATE: state_d = ST_DIFF_VEL;
          default:            state_d = ST_MUL_A;
        endcase
      end
      ST_INIT: begin
        cmd_o.op = vkt_pkg::DP_INIT;
        state_d  = ST_SQ_X;
      end
      ST_DIFF_VEL: begin
        cmd_o.op = vkt_pkg::DP_DIFF_VEL;
        state_d  = ST_DIFF_ACC;
      end
      ST_DIFF_ACC: begin
        cmd_o.op = vkt_pkg::DP_DIFF_ACC;
        state_d  = ST_SQ_X;
      end
      ST_SQ_X: begin
        cmd_o.op = vkt_pkg::DP_SQ_X;
        state_d  = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd_o.op = vkt_pkg::DP_SQ_Y;
        state_d  = ST_SQ_SUM;
      end
      ST_SQ_SUM: begin
        cmd_o.op = vkt_pkg::DP_SQ_SUM;
        cnt_d    = '0;
        state_d  = ST_ITER;
      end
      ST_ITER: begin
        cmd_o.op = vkt_pkg::DP_ITER;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == vkt_pkg::ITER_CNT_W'(vkt_pkg::ITER_COUNT - 1)) begin
          state_d = ST_LANE;
        end
      end
      ST_LANE: begin
        cmd_o.op = vkt_pkg::DP_LANE;
        state_d  = ST_MUL_A;
      end
      ST_MUL_A: begin
        cmd_o.op = vkt_pkg::DP_MUL_A;
        state_d  = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd_o.op = vkt_pkg::DP_SPLIT;
        state_d  = ST_MUL_PH;
      end
      ST_MUL_PH: begin
        cmd_o.op = vkt_pkg::DP_MUL_PH;
        state_d  = ST_MUL_PL;
      end
      ST_MUL_PL: begin
        cmd_o.op = vkt_pkg::DP_MUL_PL;
        state_d  = ST_HAT_Y;
      end
      ST_HAT_Y: begin
        cmd_o.op = vkt_pkg::DP_HAT_Y;
        state_d  = ST_HAT_POS;
      end
      ST_HAT_POS: begin
        cmd_o.op = vkt_pkg::DP_HAT_POS;
        state_d  = ST_MUL_V;
      end
      ST_MUL_V: begin
        cmd_o.op = vkt_pkg::DP_MUL_V;
        state_d  = ST_ADD_V;
      end
      ST_ADD_V: begin
        cmd_o.op = vkt_pkg::DP_ADD_V;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ST_MUL_A;
        end else begin
          state_d = ST_MUL_SPD;
        end
      end
      ST_MUL_SPD: begin
        cmd_o.op = vkt_pkg::DP_MUL_SPD;
        state_d  = ST_ADD_SPD;
      end
      ST_ADD_SPD: begin
        cmd_o.op = vkt_pkg::DP_ADD_SPD;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.op    = vkt_pkg::DP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/vehicle_kinematic_tracker.sv]
// Top level of the vehicle kinematic tracker: sequencer, datapath and port checks.
//
// The block tracks one vehicle in road coordinates, s/d values signed Q16.16. Every
// input transaction carries an op: init loads s and d and clears the rates, update
// takes a new sample and forms velocity and acceleration by differences, predict
// evaluates the constant-acceleration model at the given horizon. Each input
// transaction yields exactly one output transaction.
// Both data channels use valid and stall; a transaction moves when valid is high and
// stall is low. The lane width register is written through a valid/ready channel,
// which is ready whenever the block has no item in work.
// Items are worked one at a time. A predict (or the no-change op) runs only the
// prediction steps; init and update also wait for the 32-step shared square root
// and lane divide that run side by side. The next item can be accepted in the
// cycle after the result is written to the output register.
// A finished result waits in the output register while the receiver stalls; the
// next item may already be accepted then, and its own result waits in the datapath
// while the sequencer holds until the output register is free.
// Reset clears the track state to zero and the lane width to four meters.
module vehicle_kinematic_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  vkt_pkg::vkt_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output vkt_pkg::vkt_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [vkt_pkg::LANE_WIDTH_W-1:0]    cfg_data_i
);

  vkt_pkg::vkt_cmd_t    cmd;
  vkt_pkg::vkt_status_t status;
  logic                 cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  vkt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_ready_o (cfg_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vkt_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

`ifndef ASSERT_OFF
  // An accepted item keeps the input side closed until its work is done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepted transaction");

  // The datapath captures input only on an accepted transaction.
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == vkt_pkg::DP_LOAD) |-> (in_valid_i && !in_stall_o))
    else $error("input captured without a transaction");

  // A new result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == vkt_pkg::DP_OUT) |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten while stalled");

  // Output valid rises only when a result was written.
  a_valid_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.op == vkt_pkg::DP_OUT))
    else $error("output valid without a written result");
`endif

endmodule
